FILE: rtl/core/cht_pkg.sv
// ----------------------------------------------------------------------------
// Chained hash table package
// Shared constants, status codes, controller states and command structs.
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int unsigned ENTRIES_DEF     = 256;
  localparam int unsigned MAX_BUCKETS_DEF = 256;
  localparam int unsigned KEY_BITS_DEF    = 32;
  localparam int unsigned ValueBits       = 32;
  localparam int unsigned CountBits       = 9;
  localparam logic [CountBits-1:0] BucketCountReset = 9'd251;

  typedef enum logic [1:0] {
    ACT_PUT    = 2'd0,
    ACT_GET    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_REPLACED  = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_FULL      = 3'd5,
    ST_CLEARED   = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DIV,
    S_HEAD,
    S_READ,
    S_CHECK,
    S_ACT,
    S_CLEAR,
    S_OUT
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic    load;       // capture request, start the bucket index reduction
    logic    div_step;   // one restoring subtract step
    logic    head_rd;    // read bucket head
    logic    ent_rd;     // read current entry
    logic    advance;    // follow link
    logic    mark_hit;   // the entry just read holds the key
    logic    do_act;     // apply the action with hit/miss known
    logic    clr_step;   // one clearing pass step
    logic    clr_start;  // reset the clearing counter
    logic    out_load;   // load result register
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic div_done;
    logic chain_end;
    logic key_hit;
    logic clr_done;
    logic is_clear;
  } stat_t;

endpackage

FILE: rtl/core/cht_ctrl.sv
// ----------------------------------------------------------------------------
// Chained hash table controller
// Sequences reduction, chain walk, action, clearing pass and result hand-off.
// ----------------------------------------------------------------------------
module cht_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  cht_pkg::stat_t stat_i,
  output cht_pkg::cmd_t  cmd_o
);

  cht_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cht_pkg::S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign in_ready_o  = (state_q == cht_pkg::S_IDLE);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      cht_pkg::S_INIT: begin
        // Clearing pass after reset refills the free stack and bucket heads.
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_done) state_d = cht_pkg::S_IDLE;
      end
      cht_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = cht_pkg::S_DIV;
        end
      end
      cht_pkg::S_DIV: begin
        if (stat_i.is_clear) begin
          cmd_o.clr_start = 1'b1;
          state_d         = cht_pkg::S_CLEAR;
        end else if (stat_i.div_done) begin
          cmd_o.head_rd = 1'b1;
          state_d       = cht_pkg::S_HEAD;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      cht_pkg::S_HEAD: begin
        state_d = cht_pkg::S_READ;
      end
      cht_pkg::S_READ: begin
        if (stat_i.chain_end) begin
          state_d = cht_pkg::S_ACT;
        end else begin
          cmd_o.ent_rd = 1'b1;
          state_d      = cht_pkg::S_CHECK;
        end
      end
      cht_pkg::S_CHECK: begin
        if (stat_i.key_hit) begin
          cmd_o.mark_hit = 1'b1;
          state_d        = cht_pkg::S_ACT;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = cht_pkg::S_READ;
        end
      end
      cht_pkg::S_ACT: begin
        cmd_o.do_act = 1'b1;
        state_d      = cht_pkg::S_OUT;
      end
      cht_pkg::S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_done) begin
          cmd_o.do_act = 1'b1;
          state_d      = cht_pkg::S_OUT;
        end
      end
      cht_pkg::S_OUT: begin
        if (!out_valid_d) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = cht_pkg::S_IDLE;
        end
      end
      default: state_d = cht_pkg::S_INIT;
    endcase
  end

endmodule

FILE: rtl/core/cht_datapath.sv
// ----------------------------------------------------------------------------
// Chained hash table datapath
// Entry memories, bucket heads, free stack, bucket reduction and result.
// ----------------------------------------------------------------------------
module cht_datapath #(
  parameter int unsigned ENTRIES     = cht_pkg::ENTRIES_DEF,
  parameter int unsigned MAX_BUCKETS = cht_pkg::MAX_BUCKETS_DEF,
  parameter int unsigned KEY_BITS    = cht_pkg::KEY_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [cht_pkg::CountBits-1:0]      cfg_wdata_i,
  input  logic [1:0]                         action_i,
  input  logic [31:0]                        key_i,
  input  logic [cht_pkg::ValueBits-1:0]      value_i,
  input  cht_pkg::cmd_t                      cmd_i,
  output cht_pkg::stat_t                     stat_o,
  output logic [2:0]                         status_o,
  output logic [cht_pkg::ValueBits-1:0]      value_out_o,
  output logic [cht_pkg::CountBits-1:0]      element_count_o
);

  localparam int unsigned EW = $clog2(ENTRIES);          // entry index bits
  localparam int unsigned LW = EW + 1;                   // link, with empty mark
  localparam int unsigned BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned CW = $clog2(MAX_BUCKETS + 1);  // divisor bits
  localparam int unsigned KW = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int unsigned SW = (ENTRIES > MAX_BUCKETS) ? LW : CW; // sweep bits
  localparam logic [LW-1:0] NoEntry = LW'(ENTRIES);

  // Configuration.
  logic [cht_pkg::CountBits-1:0] bcount_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bcount_q <= cht_pkg::BucketCountReset;
    else if (cfg_we_i) bcount_q <= cfg_wdata_i;
  end

  logic [CW-1:0] divisor;
  always_comb begin
    if (bcount_q == '0) divisor = CW'(1);
    else if (32'(bcount_q) > 32'(MAX_BUCKETS)) divisor = CW'(MAX_BUCKETS);
    else divisor = CW'(bcount_q);
  end

  // Memories.
  logic [KW-1:0]                 keys_mem [ENTRIES];
  logic [cht_pkg::ValueBits-1:0] vals_mem [ENTRIES];
  logic [LW-1:0]                 link_mem [ENTRIES];
  logic [EW-1:0]                 free_mem [ENTRIES];
  logic [LW-1:0]                 head_mem [MAX_BUCKETS];

  // Request registers.
  logic [1:0]                    act_q;
  logic [KW-1:0]                 key_q;
  logic [cht_pkg::ValueBits-1:0] val_q;
  logic [CW-1:0]                 rem_q, rem_d;   // restoring division remainder
  logic [5:0]                    dcnt_q;
  logic [LW-1:0]                 cur_q, prev_q, head_q;
  logic [KW-1:0]                 ekey_q;
  logic [cht_pkg::ValueBits-1:0] eval_q;
  logic [LW-1:0]                 elink_q;
  logic [LW-1:0]                 free_top_q;
  logic [cht_pkg::CountBits-1:0] held_q;
  logic [SW-1:0]                 clr_q;
  logic                          hit_q;
  logic [2:0]                    st_q;
  logic [cht_pkg::ValueBits-1:0] vout_q;
  logic [31:0]                   qbits_q;

  logic [BW-1:0] bucket;
  assign bucket = BW'(rem_q);

  // One remainder bit per step: shift in a key bit, subtract if it fits.
  logic [CW:0] trial;
  always_comb begin
    trial = {rem_q, qbits_q[31]} - {1'b0, divisor};
    if (!trial[CW]) rem_d = trial[CW-1:0];
    else rem_d = CW'({rem_q, qbits_q[31]});
  end

  logic [EW-1:0] cur_idx, prev_idx, top_idx;
  assign cur_idx  = cur_q[EW-1:0];
  assign prev_idx = prev_q[EW-1:0];
  assign top_idx  = EW'(free_top_q - LW'(1));

  logic clr_done;
  assign clr_done = (32'(clr_q) >= ((ENTRIES > MAX_BUCKETS) ? ENTRIES : MAX_BUCKETS) - 1);

  assign stat_o.div_done  = (dcnt_q == 6'd32);
  assign stat_o.chain_end = (32'(cur_q) >= ENTRIES);
  assign stat_o.key_hit   = (ekey_q == key_q);
  assign stat_o.clr_done  = clr_done;
  assign stat_o.is_clear  = (act_q == cht_pkg::ACT_CLEAR);

  logic clr_act;
  assign clr_act = cmd_i.clr_step;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_top_q <= LW'(ENTRIES);
      held_q     <= '0;
      clr_q      <= '0;
    end else begin
      if (cmd_i.clr_start) clr_q <= '0;
      else if (clr_act && !clr_done) clr_q <= clr_q + SW'(1);
      if (clr_act && clr_done) begin
        free_top_q <= LW'(ENTRIES);
        held_q     <= '0;
      end else if (cmd_i.do_act && act_q == cht_pkg::ACT_PUT && !hit_q &&
                   free_top_q != '0) begin
        free_top_q <= free_top_q - LW'(1);
        held_q     <= held_q + cht_pkg::CountBits'(1);
      end else if (cmd_i.do_act && act_q == cht_pkg::ACT_REMOVE && hit_q) begin
        if (32'(free_top_q) < ENTRIES) free_top_q <= free_top_q + LW'(1);
        if (held_q != '0) held_q <= held_q - cht_pkg::CountBits'(1);
      end
    end
  end

  // Request and walk registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q   <= action_i;
      key_q   <= KW'(key_i);
      val_q   <= value_i;
      qbits_q <= 32'(KW'(key_i));
      rem_q   <= '0;
      dcnt_q  <= '0;
      hit_q   <= 1'b0;
      prev_q  <= NoEntry;
    end
    if (cmd_i.div_step) begin
      rem_q   <= rem_d;
      qbits_q <= {qbits_q[30:0], 1'b0};
      dcnt_q  <= dcnt_q + 6'd1;
    end
    if (cmd_i.head_rd) begin
      cur_q  <= head_mem[bucket];
      head_q <= head_mem[bucket];
    end
    if (cmd_i.ent_rd) begin
      ekey_q  <= keys_mem[cur_idx];
      eval_q  <= vals_mem[cur_idx];
      elink_q <= link_mem[cur_idx];
    end
    if (cmd_i.mark_hit) begin
      hit_q <= 1'b1;
    end
    if (cmd_i.advance) begin
      prev_q <= cur_q;
      cur_q  <= elink_q;
    end
    if (cmd_i.do_act) begin
      vout_q <= (act_q == cht_pkg::ACT_GET && hit_q) ? eval_q : '0;
      case (act_q)
        cht_pkg::ACT_PUT: begin
          if (hit_q) st_q <= cht_pkg::ST_REPLACED;
          else if (free_top_q == '0) st_q <= cht_pkg::ST_FULL;
          else st_q <= cht_pkg::ST_INSERTED;
        end
        cht_pkg::ACT_GET: begin
          st_q <= hit_q ? cht_pkg::ST_FOUND : cht_pkg::ST_NOT_FOUND;
        end
        cht_pkg::ACT_REMOVE: st_q <= hit_q ? cht_pkg::ST_REMOVED : cht_pkg::ST_NOT_FOUND;
        default: st_q <= cht_pkg::ST_CLEARED;
      endcase
    end
  end

  // Free stack top read, registered ahead of the action.
  logic [EW-1:0] free_e_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.head_rd) free_e_q <= free_mem[top_idx];
  end

  // Memory writes: one address per memory per cycle.
  always_ff @(posedge clk_i) begin
    if (clr_act) begin
      if (32'(clr_q) < ENTRIES)     free_mem[EW'(clr_q)] <= EW'(clr_q);
      if (32'(clr_q) < MAX_BUCKETS) head_mem[BW'(clr_q)] <= NoEntry;
    end else if (cmd_i.do_act) begin
      case (act_q)
        cht_pkg::ACT_PUT: begin
          if (hit_q) begin
            vals_mem[cur_idx] <= val_q;
          end else if (free_top_q != '0) begin
            keys_mem[free_e_q] <= key_q;
            vals_mem[free_e_q] <= val_q;
            link_mem[free_e_q] <= head_q;
            head_mem[bucket]   <= LW'(free_e_q);
          end
        end
        cht_pkg::ACT_REMOVE: begin
          if (hit_q) begin
            if (prev_q == NoEntry) head_mem[bucket] <= elink_q;
            else link_mem[prev_idx] <= elink_q;
            if (32'(free_top_q) < ENTRIES) free_mem[EW'(free_top_q)] <= cur_idx;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o        <= st_q;
      value_out_o     <= vout_q;
      element_count_o <= held_q;
    end
  end

endmodule

FILE: rtl/core/chained_hash_table_core.sv
// ----------------------------------------------------------------------------
// Chained hash table core
// Key-value store with separate chaining over a fixed entry pool.
// ----------------------------------------------------------------------------
// Requests (action, key, value) enter on in_valid_i/in_ready_o; one result
// (status, value_out, element_count) leaves on out_valid_o/out_ready_i.
// A request is taken only while the core is idle, one at a time.
// Steps: a load, bit-serial key reduction (one key bit per cycle against
// the bucket count), a head read, then a read and a check per chain
// entry visited, an action and an output step. A clear sweeps
// max(ENTRIES, MAX_BUCKETS) addresses through the head and free-stack
// memories. After reset the same clearing pass runs with in_ready_o low;
// bucket_count resets to 251. The result sits in an output register; if the
// receiver stalls the core holds the next result until that register frees
// up. bucket_count is written through cfg_we_i/cfg_wdata_i; the user must
// write it only while idle, which the core itself does not enforce.
// ----------------------------------------------------------------------------
module chained_hash_table_core #(
  parameter int unsigned ENTRIES     = cht_pkg::ENTRIES_DEF,
  parameter int unsigned MAX_BUCKETS = cht_pkg::MAX_BUCKETS_DEF,
  parameter int unsigned KEY_BITS    = cht_pkg::KEY_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cht_pkg::CountBits-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    action_i,
  input  logic [31:0]                   key_i,
  input  logic [cht_pkg::ValueBits-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    status_o,
  output logic [cht_pkg::ValueBits-1:0] value_out_o,
  output logic [cht_pkg::CountBits-1:0] element_count_o
);

  cht_pkg::cmd_t  cmd;
  cht_pkg::stat_t stat;

  cht_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  cht_datapath #(
    .ENTRIES(ENTRIES), .MAX_BUCKETS(MAX_BUCKETS), .KEY_BITS(KEY_BITS)
  ) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .action_i, .key_i, .value_i,
    .cmd_i(cmd), .stat_o(stat), .status_o, .value_out_o, .element_count_o
  );

endmodule

FILE: rtl/core/cht_checker.sv
// ----------------------------------------------------------------------------
// Chained hash table port checker
// Port-level properties, bound to the core.
// ----------------------------------------------------------------------------
module cht_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] status_o,
  input logic [8:0] element_count_o
);

  // A result always carries one of the defined status codes.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= cht_pkg::ST_CLEARED))
    else $error("bad status");

  // After a request is taken, the core is busy the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready after accept");

  // A pending result holds until taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(status_o))
    else $error("result dropped");

  // A cleared result always reports zero entries.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == cht_pkg::ST_CLEARED) |-> element_count_o == 9'd0)
    else $error("clear count");

endmodule

bind chained_hash_table_core cht_checker u_cht_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .status_o, .element_count_o
);

FILE: verif/chained_hash_table_core_checker.sv
// ----------------------------------------------------------------------------
// Chained hash table checker
// Watches both channels, predicts each result and compares field by field.
// ----------------------------------------------------------------------------
module chained_hash_table_core_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cht_pkg::CountBits-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [1:0]                    action_i,
  input  logic [31:0]                   key_i,
  input  logic [31:0]                   value_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [2:0]                    status_i,
  input  logic [31:0]                   value_out_i,
  input  logic [8:0]                    element_count_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumEntries = 256;
  localparam int unsigned NumBuckets = 256;
  localparam logic [8:0]  NoEntry    = 9'd256;

  typedef struct packed {
    cht_pkg::status_e status;
    logic [31:0]      value;
    logic [8:0]       count;
  } table_result_t;

  logic [8:0]  divisor_q;
  logic [8:0]  heads_q [NumBuckets];
  logic [31:0] keys_q [NumEntries];
  logic [31:0] vals_q [NumEntries];
  logic [8:0]  links_q [NumEntries];
  logic [8:0]  free_q [NumEntries];
  logic [8:0]  free_top_q;
  logic [8:0]  held_q;
  table_result_t expected_results[$];

  function automatic void empty_table();
    for (int i = 0; i < NumBuckets; i++) heads_q[i] = NoEntry;
    for (int i = 0; i < NumEntries; i++) free_q[i] = 9'(i);
    free_top_q = 9'(NumEntries);
    held_q = '0;
  endfunction

  function automatic table_result_t apply_request(cht_pkg::action_e act, logic [31:0] key,
                                                  logic [31:0] val);
    table_result_t res;
    int unsigned d, b, prev, cur, steps, e;
    logic hit;
    res.status = cht_pkg::ST_NOT_FOUND;
    res.value = '0;
    if (act == cht_pkg::ACT_CLEAR) begin
      empty_table();
      res.status = cht_pkg::ST_CLEARED;
    end else begin
      d = divisor_q;
      if (d == 0) d = 1;
      if (d > NumBuckets) d = NumBuckets;
      b = key % d;
      prev = NoEntry;
      cur = heads_q[b];
      steps = 0;
      hit = 1'b0;
      while (cur < NumEntries && steps < NumEntries) begin
        if (keys_q[cur] == key) begin
          hit = 1'b1;
          break;
        end
        prev = cur;
        cur = links_q[cur];
        steps++;
      end
      case (act)
        cht_pkg::ACT_PUT: begin
          if (hit) begin
            vals_q[cur] = val;
            res.status = cht_pkg::ST_REPLACED;
          end else if (free_top_q == 0) begin
            res.status = cht_pkg::ST_FULL;
          end else begin
            free_top_q--;
            e = free_q[free_top_q % NumEntries] % NumEntries;
            keys_q[e] = key;
            vals_q[e] = val;
            links_q[e] = heads_q[b];
            heads_q[b] = 9'(e);
            held_q++;
            res.status = cht_pkg::ST_INSERTED;
          end
        end
        cht_pkg::ACT_GET: begin
          if (hit) begin
            res.value = vals_q[cur];
            res.status = cht_pkg::ST_FOUND;
          end
        end
        default: begin
          if (hit) begin
            if (prev == NoEntry) heads_q[b] = links_q[cur];
            else links_q[prev] = links_q[cur];
            if (free_top_q < NumEntries) begin
              free_q[free_top_q] = 9'(cur);
              free_top_q++;
            end
            if (held_q > 0) held_q--;
            res.status = cht_pkg::ST_REMOVED;
          end
        end
      endcase
    end
    res.count = held_q;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    divisor_q = cht_pkg::BucketCountReset;
    empty_table();
  end

  assign pending_o = expected_results.size();

  always @(posedge clk_i) begin
    table_result_t want;
    if (rst_ni) begin
      if (cfg_we_i) divisor_q <= cfg_wdata_i;
      if (in_valid_i && in_ready_i)
        expected_results.push_back(apply_request(cht_pkg::action_e'(action_i), key_i,
                                                 value_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 32'(status_i), '0);
        end else begin
          want = expected_results.pop_front();
          if (status_i != want.status)
            report_mismatch("status", 32'(status_i), 32'(want.status));
          if (value_out_i != want.value) report_mismatch("value_out", value_out_i, want.value);
          if (element_count_i != want.count)
            report_mismatch("element_count", 32'(element_count_i), 32'(want.count));
        end
      end
    end
  end
endmodule

FILE: verif/chained_hash_table_core_test.sv
// ----------------------------------------------------------------------------
// Chained hash table testbench
// Drives directed and random requests and bucket counts; the checker judges.
// ----------------------------------------------------------------------------
module chained_hash_table_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 3_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [8:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i = '0;
  logic [31:0] key_i = '0;
  logic [31:0] value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [31:0] value_out_o;
  logic [8:0]  element_count_o;
  int          fail_count;
  int          pending;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          cycles;
  logic [31:0] used_keys[$];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  chained_hash_table_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .action_i, .key_i, .value_i, .out_valid_o, .out_ready_i,
    .status_o, .value_out_o, .element_count_o
  );

  chained_hash_table_core_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_i(in_ready_o),
    .action_i, .key_i, .value_i, .out_valid_i(out_valid_o), .out_ready_i,
    .status_i(status_o), .value_out_i(value_out_o), .element_count_i(element_count_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[chained_hash_table_core] ERROR");
      $finish;
    end
  end

  // Valid is driven with blocking writes so that a drop and a new request
  // at the same falling edge resolve to the last one.
  task automatic send_request(cht_pkg::action_e act, logic [31:0] key, logic [31:0] val);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid_i = 1'b1;
    action_i <= act;
    key_i <= key;
    value_i <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    if (act == cht_pkg::ACT_PUT) used_keys.push_back(key);
  endtask

  // The table must be quiet before the bucket count moves.
  task automatic set_bucket_count(logic [8:0] count);
    while (pending != 0) @(negedge clk_i);
    repeat (600) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= count;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_key();
    if (used_keys.size() != 0 && $urandom_range(99) < 70)
      return used_keys[$urandom_range(used_keys.size() - 1)];
    if ($urandom_range(1)) return $urandom_range(1023);
    return $urandom();
  endfunction

  task automatic random_phase(int count);
    int roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 45) send_request(cht_pkg::ACT_PUT, pick_key(), $urandom());
      else if (roll < 75) send_request(cht_pkg::ACT_GET, pick_key(), $urandom());
      else if (roll < 98) send_request(cht_pkg::ACT_REMOVE, pick_key(), $urandom());
      else send_request(cht_pkg::ACT_CLEAR, $urandom(), $urandom());
    end
  endtask

  initial begin
    cycles = 0;
    send_idle_pct = 22;
    recv_idle_pct = 84;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_request(cht_pkg::ACT_GET, 32'd0, 32'hFFFF_FFFF);
    send_request(cht_pkg::ACT_PUT, 32'd0, 32'hFFFF_FFFF);
    send_request(cht_pkg::ACT_PUT, 32'hFFFF_FFFF, 32'd0);
    send_request(cht_pkg::ACT_PUT, 32'd251, 32'h1234_5678);
    send_request(cht_pkg::ACT_PUT, 32'd0, 32'hA5A5_5A5A);
    send_request(cht_pkg::ACT_GET, 32'd0, '0);
    send_request(cht_pkg::ACT_GET, 32'd251, '0);
    send_request(cht_pkg::ACT_REMOVE, 32'd0, '0);
    send_request(cht_pkg::ACT_REMOVE, 32'd0, '0);
    send_request(cht_pkg::ACT_GET, 32'hFFFF_FFFF, '0);
    send_request(cht_pkg::ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(cht_pkg::ACT_GET, 32'd251, '0);

    // Fill the pool through a single chain, then overflow it.
    set_bucket_count(9'd1);
    for (int i = 0; i < 257; i++) send_request(cht_pkg::ACT_PUT, 32'(i * 7), 32'(i));
    send_request(cht_pkg::ACT_PUT, 32'd3, 32'd1);
    send_request(cht_pkg::ACT_PUT, 32'd7, 32'd99);
    send_request(cht_pkg::ACT_REMOVE, 32'd700, '0);
    // Entries stranded by a new divisor stay counted until a clear.
    set_bucket_count(9'd0);
    send_request(cht_pkg::ACT_GET, 32'd14, '0);
    set_bucket_count(9'd511);
    send_request(cht_pkg::ACT_GET, 32'd14, '0);
    send_request(cht_pkg::ACT_PUT, 32'd5, '0);
    send_request(cht_pkg::ACT_CLEAR, '0, '0);

    set_bucket_count(9'd256);
    random_phase(450);
    set_bucket_count(9'd3);
    random_phase(250);

    send_idle_pct = 84;
    recv_idle_pct = 22;
    set_bucket_count(9'd1);
    random_phase(200);
    set_bucket_count(9'd17);
    random_phase(250);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_bucket_count(9'd256);
    random_phase(250);
    set_bucket_count(9'h1AA);
    random_phase(200);

    while (pending != 0) @(negedge clk_i);
    repeat (600) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("[chained_hash_table_core] OK");
    end else begin
      $display("[chained_hash_table_core] ERROR");
    end
    $finish;
  end
endmodule
